@@ rtl/uvs_pkg.sv @@
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared constants, types and helpers for the UV sphere vertex unit.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int GRID_BITS  = 10;
    localparam int FRAC_BITS  = 15;
    localparam int IDX_BITS   = 20;
    localparam int POS_BITS   = 16;
    localparam int TURN_BITS  = 32;
    localparam int Q_BITS     = 30;
    localparam int MAG_BITS   = Q_BITS + 1;
    localparam int CFG_IDX_BITS = 2;

    // divider: 32 quotient bits, 4 per stage
    localparam int DIV_STEPS     = TURN_BITS;
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;

    // trig: fold, scale, square, 3 stages per Horner step, final product
    localparam int HORNER_STEPS = 6;
    localparam int SIN_STEPS    = 5;
    localparam int TRIG_STAGES  = 3 + 3 * HORNER_STEPS + 1;

    localparam int SIDE_DEPTH = DIV_STAGES + TRIG_STAGES;
    localparam int LATENCY    = SIDE_DEPTH + 3;

    localparam logic [GRID_BITS-1:0] SECTOR_RESET = GRID_BITS'(36);
    localparam logic [GRID_BITS-1:0] STACK_RESET  = GRID_BITS'(18);

    localparam logic [MAG_BITS-1:0] Q30_ONE     = MAG_BITS'(1) << Q_BITS;
    localparam logic [MAG_BITS-1:0] HALF_PI_Q30 = MAG_BITS'(1686629713);
    localparam logic [63:0]         Q30_HALF    = 64'd1 << (Q_BITS - 1);

    // Horner divisors and floor(2^32/k) reciprocals
    localparam logic [7:0] COS_K [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [7:0] SIN_K [HORNER_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd1};
    localparam logic [31:0] COS_RECIP [HORNER_STEPS] = '{
        32'd32537631, 32'd47721858, 32'd76695844,
        32'd143165576, 32'd357913941, 32'd2147483648};
    localparam logic [31:0] SIN_RECIP [HORNER_STEPS] = '{
        32'd39045157, 32'd59652323, 32'd102261126,
        32'd214748364, 32'd715827882, 32'd0};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SECTOR_COUNT = 2'd0,
        REG_STACK_COUNT  = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic                s_neg;
        logic                c_neg;
        logic [MAG_BITS-1:0] s_mag;
        logic [MAG_BITS-1:0] c_mag;
    } trig_res_t;

    typedef struct packed {
        logic                vld;
        logic                point_ok;
        logic                quad_ok;
        logic [IDX_BITS-1:0] here;
        logic [IDX_BITS-1:0] below;
    } side_t;

    // sign/magnitude to saturated 16-bit two's complement
    function automatic logic [POS_BITS-1:0] pack_pos(input logic neg, input logic [47:0] mag);
        logic [47:0] m;
        m = mag;
        if (mag == 48'd0) begin
            return '0;
        end
        if (neg) begin
            if (m > 48'd32768) begin
                m = 48'd32768;
            end
            return POS_BITS'(48'h10000 - m);
        end
        if (m > 48'd32767) begin
            m = 48'd32767;
        end
        return POS_BITS'(m);
    endfunction

endpackage

@@ rtl/uvs_div.sv @@
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, four quotient bits per stage.
// ----------------------------------------------------------------------------
module uvs_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_vld,
    input  logic [uvs_pkg::GRID_BITS-1:0]  in_rem,
    input  logic [uvs_pkg::GRID_BITS-1:0]  in_div,
    input  logic [uvs_pkg::TURN_BITS-1:0]  in_word,
    output logic                           out_vld,
    output logic [uvs_pkg::TURN_BITS-1:0]  out_quot
);
    import uvs_pkg::*;

    logic                 vld_reg  [DIV_STAGES];
    logic [GRID_BITS-1:0] rem_reg  [DIV_STAGES];
    logic [GRID_BITS-1:0] div_reg  [DIV_STAGES];
    logic [TURN_BITS-1:0] word_reg [DIV_STAGES];
    logic [GRID_BITS-1:0] rem_next  [DIV_STAGES];
    logic [TURN_BITS-1:0] word_next [DIV_STAGES];

    // word shifts out dividend bits at the top and takes quotient bits in
    always_comb
    begin
        logic [GRID_BITS-1:0] rem_v;
        logic [TURN_BITS-1:0] word_v;
        logic [GRID_BITS-1:0] div_v;
        logic [GRID_BITS:0]   trial;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                rem_v  = in_rem;
                word_v = in_word;
                div_v  = in_div;
            end
            else
            begin
                rem_v  = rem_reg[(s == 0) ? 0 : s - 1];
                word_v = word_reg[(s == 0) ? 0 : s - 1];
                div_v  = div_reg[(s == 0) ? 0 : s - 1];
            end
            for (int j = 0; j < DIV_PER_STAGE; j++)
            begin
                trial  = {rem_v, word_v[TURN_BITS-1]};
                word_v = {word_v[TURN_BITS-2:0], 1'b0};
                if (trial >= {1'b0, div_v})
                begin
                    rem_v     = GRID_BITS'(trial - {1'b0, div_v});
                    word_v[0] = 1'b1;
                end
                else
                begin
                    rem_v = trial[GRID_BITS-1:0];
                end
            end
            rem_next[s]  = rem_v;
            word_next[s] = word_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg[0] <= in_div;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            div_reg[s] <= div_reg[s-1];
        end
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_reg[s]  <= rem_next[s];
            word_reg[s] <= word_next[s];
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_quot = word_reg[DIV_STAGES-1];

endmodule

@@ rtl/uvs_trig.sv @@
// ----------------------------------------------------------------------------
// uvs_trig
// Pipelined sine/cosine of a Q0.32 turn fraction, Horner polynomial form.
// ----------------------------------------------------------------------------
module uvs_trig (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_vld,
    input  logic [uvs_pkg::TURN_BITS-1:0] in_turn,
    output logic                          out_vld,
    output uvs_pkg::trig_res_t            out_res
);
    import uvs_pkg::*;

    localparam int CTL_DEPTH = TRIG_STAGES - 1;

    typedef struct packed {
        logic              swap;
        logic [1:0]        quad;
        logic [Q_BITS-1:0] r;
        logic [Q_BITS-1:0] r2;
    } ctl_t;

    logic vld_reg [TRIG_STAGES];
    ctl_t ctl_reg  [CTL_DEPTH];
    ctl_t ctl_next [CTL_DEPTH];

    logic [Q_BITS-1:0]   pa_c_reg [HORNER_STEPS];
    logic [Q_BITS-1:0]   pb_c_reg [HORNER_STEPS];
    logic [Q_BITS-1:0]   qb_c_reg [HORNER_STEPS];
    logic [MAG_BITS-1:0] tc_reg   [HORNER_STEPS];
    logic [Q_BITS-1:0]   pa_s_reg [SIN_STEPS];
    logic [Q_BITS-1:0]   pb_s_reg [SIN_STEPS];
    logic [Q_BITS-1:0]   qb_s_reg [SIN_STEPS];
    logic [MAG_BITS-1:0] ts_reg   [HORNER_STEPS];
    logic [MAG_BITS-1:0] ts_hold1_reg;
    logic [MAG_BITS-1:0] ts_hold2_reg;
    trig_res_t           res_reg;

    // fold into the first octant, scale to radians, square
    always_comb
    begin
        logic [Q_BITS-1:0] f;
        logic              swap;
        logic [63:0]       prod_r;
        logic [63:0]       prod_r2;
        f       = in_turn[Q_BITS-1:0];
        swap    = f > (Q_BITS'(1) << (Q_BITS - 1));
        prod_r  = 64'(ctl_reg[0].r) * 64'(HALF_PI_Q30) + Q30_HALF;
        prod_r2 = 64'(ctl_reg[1].r) * 64'(ctl_reg[1].r) + Q30_HALF;
        ctl_next[0].swap = swap;
        ctl_next[0].quad = in_turn[TURN_BITS-1:Q_BITS];
        ctl_next[0].r    = swap ? Q_BITS'(Q30_ONE - MAG_BITS'(f)) : f;
        ctl_next[0].r2   = '0;
        for (int s = 1; s < CTL_DEPTH; s++)
        begin
            ctl_next[s] = ctl_reg[s-1];
        end
        ctl_next[1].r  = Q_BITS'(prod_r >> Q_BITS);
        ctl_next[2].r2 = Q_BITS'(prod_r2 >> Q_BITS);
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < CTL_DEPTH; s++)
        begin
            ctl_reg[s] <= ctl_next[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TRIG_STAGES; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int s = 1; s < TRIG_STAGES; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // each step: t = 1 - floor(m(r2,t)/k); multiply, reciprocal, correct
    for (genvar i = 0; i < HORNER_STEPS; i++)
    begin : g_step
        logic [MAG_BITS-1:0] tc_in;
        logic [Q_BITS-1:0]   r2_in;
        logic [MAG_BITS-1:0] rem_c;
        logic [Q_BITS-1:0]   q_c;

        assign r2_in = ctl_reg[2 + 3 * i].r2;

        if (i == 0)
        begin : g_first
            assign tc_in = Q30_ONE;
        end
        else
        begin : g_next
            assign tc_in = tc_reg[i-1];
        end

        assign rem_c = MAG_BITS'(pb_c_reg[i]) - MAG_BITS'(qb_c_reg[i]) * MAG_BITS'(COS_K[i]);
        assign q_c   = (rem_c >= MAG_BITS'(COS_K[i])) ? qb_c_reg[i] + Q_BITS'(1) : qb_c_reg[i];

        always_ff @(posedge clk)
        begin
            pa_c_reg[i] <= Q_BITS'((64'(r2_in) * 64'(tc_in) + Q30_HALF) >> Q_BITS);
            pb_c_reg[i] <= pa_c_reg[i];
            qb_c_reg[i] <= Q_BITS'((64'(pa_c_reg[i]) * 64'(COS_RECIP[i])) >> 32);
            tc_reg[i]   <= Q30_ONE - MAG_BITS'(q_c);
        end

        if (i < SIN_STEPS)
        begin : g_sin
            logic [MAG_BITS-1:0] ts_in;
            logic [MAG_BITS-1:0] rem_s;
            logic [Q_BITS-1:0]   q_s;

            if (i == 0)
            begin : g_sfirst
                assign ts_in = Q30_ONE;
            end
            else
            begin : g_snext
                assign ts_in = ts_reg[i-1];
            end

            assign rem_s = MAG_BITS'(pb_s_reg[i]) - MAG_BITS'(qb_s_reg[i]) * MAG_BITS'(SIN_K[i]);
            assign q_s   = (rem_s >= MAG_BITS'(SIN_K[i])) ? qb_s_reg[i] + Q_BITS'(1)
                                                          : qb_s_reg[i];

            always_ff @(posedge clk)
            begin
                pa_s_reg[i] <= Q_BITS'((64'(r2_in) * 64'(ts_in) + Q30_HALF) >> Q_BITS);
                pb_s_reg[i] <= pa_s_reg[i];
                qb_s_reg[i] <= Q_BITS'((64'(pa_s_reg[i]) * 64'(SIN_RECIP[i])) >> 32);
                ts_reg[i]   <= Q30_ONE - MAG_BITS'(q_s);
            end
        end
        else
        begin : g_sin_hold
            // sine series is one term shorter: just keep pace
            always_ff @(posedge clk)
            begin
                ts_hold1_reg <= ts_reg[i-1];
                ts_hold2_reg <= ts_hold1_reg;
                ts_reg[i]    <= ts_hold2_reg;
            end
        end
    end

    // final sine product, undo the fold, quadrant signs
    always_ff @(posedge clk)
    begin
        logic [MAG_BITS-1:0] s0;
        logic [MAG_BITS-1:0] c0;
        logic [MAG_BITS-1:0] s1;
        logic [MAG_BITS-1:0] c1;
        s0 = MAG_BITS'((64'(ctl_reg[CTL_DEPTH-1].r) * 64'(ts_reg[HORNER_STEPS-1]) + Q30_HALF)
                       >> Q_BITS);
        c0 = tc_reg[HORNER_STEPS-1];
        s1 = ctl_reg[CTL_DEPTH-1].swap ? c0 : s0;
        c1 = ctl_reg[CTL_DEPTH-1].swap ? s0 : c0;
        case (ctl_reg[CTL_DEPTH-1].quad)
            2'd0:
            begin
                res_reg <= '{s_neg: 1'b0, c_neg: 1'b0, s_mag: s1, c_mag: c1};
            end
            2'd1:
            begin
                res_reg <= '{s_neg: 1'b0, c_neg: 1'b1, s_mag: c1, c_mag: s1};
            end
            2'd2:
            begin
                res_reg <= '{s_neg: 1'b1, c_neg: 1'b1, s_mag: s1, c_mag: c1};
            end
            default:
            begin
                res_reg <= '{s_neg: 1'b1, c_neg: 1'b0, s_mag: c1, c_mag: s1};
            end
        endcase
    end

    assign out_vld = vld_reg[TRIG_STAGES-1];
    assign out_res = res_reg;

endmodule

@@ rtl/uv_sphere_vertex_index_generator_unit.sv @@
// ----------------------------------------------------------------------------
// uv_sphere_vertex_index_generator_unit
// UV sphere grid point to unit-sphere position, vertex and quad indices.
// ----------------------------------------------------------------------------
// Usage: pulse start with a column/row pair; busy is always low, so a new
// item can be issued every clock. Each item produces exactly one result,
// marked by a one-cycle done strobe, after it passes the input register,
// the 8-stage divider for the turn fractions, the 22-stage sine/cosine
// pipeline, the product stage and the output register. Results come out
// in issue order and cannot be held off: the receiver must take them as
// they appear. Sector and stack counts are written through the cfg port
// (cfg_ready is always high) and must only change while no item is in
// flight. A count of zero is treated as one. Points outside the grid
// return all zeros with point_valid low; points on the last row or column
// return zero triangle indices with quad_valid low.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_index_generator_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [uvs_pkg::GRID_BITS-1:0]        column,
    input  logic [uvs_pkg::GRID_BITS-1:0]        row,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  uvs_pkg::cfg_reg_t                    cfg_index,
    input  logic [uvs_pkg::GRID_BITS-1:0]        cfg_data,
    output logic                                 done,
    output logic signed [uvs_pkg::POS_BITS-1:0]  pos_x,
    output logic signed [uvs_pkg::POS_BITS-1:0]  pos_y,
    output logic signed [uvs_pkg::POS_BITS-1:0]  pos_z,
    output logic [uvs_pkg::IDX_BITS-1:0]         vertex_number,
    output logic [uvs_pkg::IDX_BITS-1:0]         tri_first_a,
    output logic [uvs_pkg::IDX_BITS-1:0]         tri_first_b,
    output logic [uvs_pkg::IDX_BITS-1:0]         tri_first_c,
    output logic [uvs_pkg::IDX_BITS-1:0]         tri_second_a,
    output logic [uvs_pkg::IDX_BITS-1:0]         tri_second_b,
    output logic [uvs_pkg::IDX_BITS-1:0]         tri_second_c,
    output logic                                 quad_valid,
    output logic                                 point_valid
);
    import uvs_pkg::*;

    localparam int PSH = 60 - FRAC_BITS;
    localparam int YSH = 30 - FRAC_BITS;
    localparam logic [63:0] RND_P = 64'd1 << (PSH - 1);
    localparam logic [63:0] RND_Y = (YSH == 0) ? 64'd0 : (64'd1 << (YSH - 1));
    localparam int PROD_BITS = 2 * MAG_BITS;

    // configuration
    logic [GRID_BITS-1:0] sector_count_reg;
    logic [GRID_BITS-1:0] stack_count_reg;

    // input stage
    logic                 s0_vld_reg;
    logic [GRID_BITS-1:0] s0_col_reg;
    logic [GRID_BITS-1:0] s0_row_reg;
    logic [GRID_BITS-1:0] s0_sc_reg;
    logic [GRID_BITS-1:0] s0_st_reg;

    // divider feeds
    logic [GRID_BITS-1:0] th_rem;
    logic [TURN_BITS-1:0] th_word;
    logic [GRID_BITS-1:0] ph_rem;
    logic [TURN_BITS-1:0] ph_word;
    logic                 th_div_vld;
    logic                 ph_div_vld;
    logic [TURN_BITS-1:0] th_turn;
    logic [TURN_BITS-1:0] ph_turn;

    // trig results
    logic      th_vld;
    logic      ph_vld;
    trig_res_t th_res;
    trig_res_t ph_res;

    // index sideband, delayed to meet the trig results
    side_t side_reg  [SIDE_DEPTH];
    side_t side_next;

    // product stage
    side_t                p1_side_reg;
    logic [PROD_BITS-1:0] p1_xprod_reg;
    logic [PROD_BITS-1:0] p1_zprod_reg;
    logic [MAG_BITS-1:0]  p1_ymag_reg;
    logic                 p1_xneg_reg;
    logic                 p1_yneg_reg;
    logic                 p1_zneg_reg;

    // output stage
    logic                done_reg;
    logic [POS_BITS-1:0] pos_x_reg;
    logic [POS_BITS-1:0] pos_y_reg;
    logic [POS_BITS-1:0] pos_z_reg;
    logic [IDX_BITS-1:0] vertex_reg;
    logic [IDX_BITS-1:0] fa_reg;
    logic [IDX_BITS-1:0] fb_reg;
    logic [IDX_BITS-1:0] fc_reg;
    logic [IDX_BITS-1:0] sa_reg;
    logic [IDX_BITS-1:0] sb_reg;
    logic [IDX_BITS-1:0] sc_reg;
    logic                quad_valid_reg;
    logic                point_valid_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_count_reg <= SECTOR_RESET;
            stack_count_reg  <= STACK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SECTOR_COUNT:
                begin
                    sector_count_reg <= cfg_data;
                end
                REG_STACK_COUNT:
                begin
                    stack_count_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // input register; zero counts act as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_col_reg <= column;
        s0_row_reg <= row;
        s0_sc_reg  <= (sector_count_reg == '0) ? GRID_BITS'(1) : sector_count_reg;
        s0_st_reg  <= (stack_count_reg == '0) ? GRID_BITS'(1) : stack_count_reg;
    end

    // Longitude: round(col*2^32/sc) mod 2^32. col == sc wraps to zero, so
    // start that case from a zero partial remainder.
    // Latitude: round(row*2^31/st), run as floor(row/2) over {row[0], st/2}.
    assign th_rem  = (s0_col_reg == s0_sc_reg) ? '0 : s0_col_reg;
    assign th_word = TURN_BITS'(s0_sc_reg >> 1);
    assign ph_rem  = s0_row_reg >> 1;
    assign ph_word = {s0_row_reg[0], (TURN_BITS-1)'(s0_st_reg >> 1)};

    uvs_div u_div_theta (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s0_vld_reg),
        .in_rem   (th_rem),
        .in_div   (s0_sc_reg),
        .in_word  (th_word),
        .out_vld  (th_div_vld),
        .out_quot (th_turn)
    );

    uvs_div u_div_phi (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s0_vld_reg),
        .in_rem   (ph_rem),
        .in_div   (s0_st_reg),
        .in_word  (ph_word),
        .out_vld  (ph_div_vld),
        .out_quot (ph_turn)
    );

    uvs_trig u_trig_theta (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (th_div_vld),
        .in_turn (th_turn),
        .out_vld (th_vld),
        .out_res (th_res)
    );

    uvs_trig u_trig_phi (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (ph_div_vld),
        .in_turn (ph_turn),
        .out_vld (ph_vld),
        .out_res (ph_res)
    );

    // vertex index row*(sc+1)+col and the one a row below
    always_comb
    begin
        logic [GRID_BITS:0]   w;
        logic [IDX_BITS:0]    here;
        w    = {1'b0, s0_sc_reg} + (GRID_BITS+1)'(1);
        here = (IDX_BITS+1)'(s0_row_reg * w) + (IDX_BITS+1)'(s0_col_reg);
        side_next.vld      = s0_vld_reg;
        side_next.point_ok = (s0_col_reg <= s0_sc_reg) && (s0_row_reg <= s0_st_reg);
        side_next.quad_ok  = (s0_col_reg < s0_sc_reg) && (s0_row_reg < s0_st_reg);
        side_next.here     = here[IDX_BITS-1:0];
        side_next.below    = IDX_BITS'(here + (IDX_BITS+1)'(w));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SIDE_DEPTH; s++)
            begin
                side_reg[s] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= side_next;
            for (int s = 1; s < SIDE_DEPTH; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // x = cos(theta) sin(phi), z = sin(theta) sin(phi), on magnitudes
    always_ff @(posedge clk)
    begin
        p1_side_reg  <= side_reg[SIDE_DEPTH-1];
        p1_xprod_reg <= PROD_BITS'(th_res.c_mag) * PROD_BITS'(ph_res.s_mag);
        p1_zprod_reg <= PROD_BITS'(th_res.s_mag) * PROD_BITS'(ph_res.s_mag);
        p1_ymag_reg  <= ph_res.c_mag;
        p1_xneg_reg  <= th_res.c_neg ^ ph_res.s_neg;
        p1_yneg_reg  <= ph_res.c_neg;
        p1_zneg_reg  <= th_res.s_neg ^ ph_res.s_neg;
    end

    // round, saturate, zero what the point does not own
    always_ff @(posedge clk)
    begin
        logic [47:0] xm;
        logic [47:0] ym;
        logic [47:0] zm;
        logic        pok;
        logic        qok;
        xm  = 48'((64'(p1_xprod_reg) + RND_P) >> PSH);
        zm  = 48'((64'(p1_zprod_reg) + RND_P) >> PSH);
        ym  = 48'((64'(p1_ymag_reg) + RND_Y) >> YSH);
        pok = p1_side_reg.point_ok;
        qok = p1_side_reg.quad_ok;
        pos_x_reg       <= pok ? pack_pos(p1_xneg_reg, xm) : '0;
        pos_y_reg       <= pok ? pack_pos(p1_yneg_reg, ym) : '0;
        pos_z_reg       <= pok ? pack_pos(p1_zneg_reg, zm) : '0;
        vertex_reg      <= pok ? p1_side_reg.here : '0;
        fa_reg          <= qok ? p1_side_reg.below : '0;
        fb_reg          <= qok ? p1_side_reg.here : '0;
        fc_reg          <= qok ? p1_side_reg.here + IDX_BITS'(1) : '0;
        sa_reg          <= qok ? p1_side_reg.below : '0;
        sb_reg          <= qok ? p1_side_reg.here + IDX_BITS'(1) : '0;
        sc_reg          <= qok ? p1_side_reg.below + IDX_BITS'(1) : '0;
        quad_valid_reg  <= qok;
        point_valid_reg <= pok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= p1_side_reg.vld;
        end
    end

    assign done          = done_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign pos_z         = pos_z_reg;
    assign vertex_number = vertex_reg;
    assign tri_first_a   = fa_reg;
    assign tri_first_b   = fb_reg;
    assign tri_first_c   = fc_reg;
    assign tri_second_a  = sa_reg;
    assign tri_second_b  = sb_reg;
    assign tri_second_c  = sc_reg;
    assign quad_valid    = quad_valid_reg;
    assign point_valid   = point_valid_reg;

`ifndef SYNTHESIS
    a_trig_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (th_vld == side_reg[SIDE_DEPTH-1].vld) && (ph_vld == th_vld))
        else $error("trig pipeline out of step with index sideband");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item result missing at fixed latency");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !point_valid) |->
            (pos_x == '0) && (pos_y == '0) && (pos_z == '0) && (vertex_number == '0))
        else $error("point outside grid gave nonzero fields");

    a_edge_tri_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !quad_valid) |->
            (tri_first_a == '0) && (tri_first_c == '0) && (tri_second_c == '0))
        else $error("non-quad point gave triangle indices");

    a_quad_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && quad_valid) |-> point_valid)
        else $error("quad flagged for point outside grid");
`endif

endmodule
